[src/clipped_box_smoother_3x3_core_macros.svh]
// Assertion helpers for the RTL of the box smoother core.
`ifndef CLIPPED_BOX_SMOOTHER_3X3_CORE_MACROS_SVH
`define CLIPPED_BOX_SMOOTHER_3X3_CORE_MACROS_SVH

// Plain property, checked on the rising clock edge and ignored during reset.
`define CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked on the rising clock edge and ignored during reset.
`define CBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[src/cbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Widths, register indexes and divider constants of the 3x3 box smoother.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int SAMPLE_W     = 16;
  localparam int COL_W        = 18;
  localparam int SUM_W        = 20;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 12;
  localparam int PEND_W       = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int RECIP_W      = 23;
  localparam int RECIP_SHIFT  = 24;
  localparam int PROD_W       = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd256;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd256;

  // Neighbourhood size: corner, edge, interior.
  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_sel_e;

  // ceil(2^24 / n); exact floor quotient for any dividend below 2^20.
  function automatic logic [RECIP_W-1:0] div_recip(div_sel_e sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_4:   r = 23'd4194304;
      DIV_6:   r = 23'd2796203;
      DIV_9:   r = 23'd1864136;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

  // n / 2 for round-half-up.
  function automatic logic [2:0] div_half(div_sel_e sel);
    logic [2:0] h;
    case (sel)
      DIV_4:   h = 3'd2;
      DIV_6:   h = 3'd3;
      DIV_9:   h = 3'd4;
      default: h = 3'd2;
    endcase
    return h;
  endfunction

endpackage

[src/cbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/clipped_box_smoother_3x3_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_box_smoother_3x3_core
// 3x3 box mean over a raster height grid, clipped at the grid borders.
// ----------------------------------------------------------------------------
// One item is taken at a time. A sample or drain request that yields no result
// passes through the line memory read, then the column update and write-back;
// one that yields a result then also takes the reciprocal multiply, which waits
// while the output register stays full because m_axis_tready is low. The two
// line memories hold no reset value; they need no clearing pass, since a frame
// only reads columns it has already written. Results trail the input by one row
// plus one sample; after the last sample of a frame, eff_w + 1 drain requests
// (tuser = 1) release the rest. A width or height write restarts the frame.
module clipped_box_smoother_3x3_core
  import cbs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] height_in
  input  logic                    s_axis_tuser,   // [0] func
  // output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [SAMPLE_W-1:0]     m_axis_tdata,   // [15:0] smoothed_height
  output logic                    m_axis_tlast,   // end_of_row
  output logic                    m_axis_tuser    // [0] end_of_frame
);

`include "clipped_box_smoother_3x3_core_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [WIDTH_REG_W-1:0]  frame_width_q, frame_width_d;
  logic [HEIGHT_REG_W-1:0] frame_height_q, frame_height_d;
  logic [ADDR_W-1:0]       col_count_q, col_count_d;
  logic [ROW_W-1:0]        row_count_q, row_count_d;
  logic [PEND_W-1:0]       pending_q, pending_d;
  logic [COL_W-1:0]        cols_q [3];
  logic [COL_W-1:0]        cols_d [3];

  // item registers
  logic                    func_q;
  logic [SAMPLE_W-1:0]     cur_q;
  logic [ADDR_W-1:0]       addr_q;

  // divider stage
  logic [SUM_W-1:0]        x_q, x_d;
  div_sel_e                sel_q, sel_d;
  logic                    emit_q, emit_d;
  logic                    eor_q, eor_d;
  logic                    eof_q, eof_d;
  logic [PROD_W-1:0]       prod;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]     out_data_q;
  logic                    out_eor_q, out_eof_q;
  logic                    out_load;

  // line memories
  logic [ADDR_W-1:0]       rd_addr;
  logic                    mem_we;
  logic [SAMPLE_W-1:0]     prev_rd, prev2_rd;

  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [WIDTH_REG_W:0]    w_plus1, pend_clamp, drain_pos;
  logic                    restart_pos;
  logic                    in_accept;

  // CALC-stage working signals
  logic                    draining;
  logic [COL_W-1:0]        base [3];
  logic [ROW_W-1:0]        r_eff;
  logic [ADDR_W-1:0]       c_eff;
  logic                    push, emit_post, hc3, vc3;
  logic [COL_W-1:0]        push_val;
  logic [SUM_W-1:0]        sum;

  assign eff_w = (frame_width_q < WIDTH_REG_W'(2)) ? WIDTH_REG_W'(2) :
                 (frame_width_q > WIDTH_REG_W'(MAX_WIDTH)) ? WIDTH_REG_W'(MAX_WIDTH) :
                 frame_width_q;
  assign eff_h = (frame_height_q < HEIGHT_REG_W'(2)) ? HEIGHT_REG_W'(2) :
                 (frame_height_q > HEIGHT_REG_W'(MAX_HEIGHT)) ? HEIGHT_REG_W'(MAX_HEIGHT) :
                 frame_height_q;

  assign w_plus1    = {1'b0, eff_w} + (WIDTH_REG_W+1)'(1);
  assign pend_clamp = ({1'b0, pending_q} > w_plus1) ? w_plus1 : {1'b0, pending_q};
  assign drain_pos  = w_plus1 - pend_clamp;
  assign draining   = (pending_q != '0);
  assign restart_pos = ({1'b0, col_count_q} >= eff_w) ||
                       ({1'b0, row_count_q} >= eff_h);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Read address is taken from the state before the item; the item is fully
  // retired before the next read, so no forwarding is needed.
  always_comb begin
    rd_addr = '0;
    if (draining) begin
      if (drain_pos < {1'b0, eff_w}) begin
        rd_addr = drain_pos[ADDR_W-1:0];
      end
    end else if (!restart_pos) begin
      rd_addr = col_count_q;
    end
  end

  cbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (cur_q),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  cbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (prev_rd),
    .raddr_i (rd_addr),
    .rdata_o (prev2_rd)
  );

  // Column update, result selection and register writes.
  always_comb begin
    push      = 1'b0;
    emit_post = 1'b0;
    hc3       = 1'b0;
    vc3       = 1'b0;
    push_val  = '0;
    emit_d    = 1'b0;
    eor_d     = 1'b0;
    eof_d     = 1'b0;
    mem_we    = 1'b0;
    r_eff     = row_count_q;
    c_eff     = col_count_q;
    for (int i = 0; i < 3; i++) begin
      base[i] = cols_q[i];
    end
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    pending_d   = pending_q;

    if (state_q == S_CALC) begin
      if (draining) begin
        if (func_q) begin
          pending_d = pend_clamp[PEND_W-1:0] - PEND_W'(1);
          push_val  = {2'b0, prev_rd} + {2'b0, prev2_rd};
          emit_d    = 1'b1;
          if (drain_pos == '0) begin
            // last point of the second-to-last row
            vc3   = (row_count_q >= ROW_W'(2));
            eor_d = 1'b1;
            push  = 1'b1;
          end else if (drain_pos < {1'b0, eff_w}) begin
            hc3       = (drain_pos >= (WIDTH_REG_W+1)'(2));
            push      = 1'b1;
            emit_post = 1'b1;
          end else begin
            eor_d = 1'b1;
            eof_d = 1'b1;
          end
          if (pend_clamp == (WIDTH_REG_W+1)'(1)) begin
            row_count_d = '0;
            col_count_d = '0;
          end
        end
      end else if (!func_q) begin
        if (restart_pos) begin
          r_eff = '0;
          c_eff = '0;
          for (int i = 0; i < 3; i++) begin
            base[i] = '0;
          end
        end
        mem_we = 1'b1;
        if (r_eff >= ROW_W'(1)) begin
          push     = 1'b1;
          push_val = {2'b0, prev_rd} + {2'b0, cur_q} +
                     ((r_eff >= ROW_W'(2)) ? {2'b0, prev2_rd} : COL_W'(0));
          if (c_eff == '0) begin
            // last point of the row two rows back
            emit_d = (r_eff >= ROW_W'(2));
            vc3    = (r_eff >= ROW_W'(3));
            eor_d  = 1'b1;
          end else begin
            emit_d    = 1'b1;
            emit_post = 1'b1;
            hc3       = (c_eff >= ADDR_W'(2));
            vc3       = (r_eff >= ROW_W'(2));
          end
        end
        if ({1'b0, c_eff} + (WIDTH_REG_W)'(1) >= eff_w) begin
          col_count_d = '0;
          if ({1'b0, r_eff} + (HEIGHT_REG_W)'(1) >= eff_h) begin
            pending_d   = w_plus1[PEND_W-1:0];
            row_count_d = r_eff;
          end else begin
            row_count_d = r_eff + ROW_W'(1);
          end
        end else begin
          col_count_d = c_eff + ADDR_W'(1);
          row_count_d = r_eff;
        end
      end
    end

    if (push) begin
      cols_d[0] = base[1];
      cols_d[1] = base[2];
      cols_d[2] = push_val;
    end else begin
      for (int i = 0; i < 3; i++) begin
        cols_d[i] = base[i];
      end
    end

    if (emit_post) begin
      sum = {2'b0, base[2]} + {2'b0, push_val} + (hc3 ? {2'b0, base[1]} : SUM_W'(0));
    end else begin
      sum = {2'b0, base[1]} + {2'b0, base[2]} + (hc3 ? {2'b0, base[0]} : SUM_W'(0));
    end

    if (hc3 && vc3) begin
      sel_d = DIV_9;
    end else if (hc3 || vc3) begin
      sel_d = DIV_6;
    end else begin
      sel_d = DIV_4;
    end
    x_d = sum + SUM_W'(div_half(sel_d));

    // a width or height register write restarts the frame
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i && (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT)) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        frame_width_d = cfg_wdata_i[WIDTH_REG_W-1:0];
      end else begin
        frame_height_d = cfg_wdata_i;
      end
      row_count_d = '0;
      col_count_d = '0;
      pending_d   = '0;
      for (int i = 0; i < 3; i++) begin
        cols_d[i] = '0;
      end
    end
  end

  // Reciprocal multiply; quotient goes straight into the output register.
  assign prod     = x_q * div_recip(sel_q);
  assign out_load = (state_q == S_DIV) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = emit_d ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      col_count_q    <= '0;
      row_count_q    <= '0;
      pending_q      <= '0;
      out_valid_q    <= 1'b0;
      emit_q         <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cols_q[i] <= '0;
      end
    end else begin
      state_q        <= state_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      col_count_q    <= col_count_d;
      row_count_q    <= row_count_d;
      pending_q      <= pending_d;
      out_valid_q    <= out_valid_d;
      if (state_q == S_CALC) begin
        emit_q <= emit_d;
      end
      for (int i = 0; i < 3; i++) begin
        cols_q[i] <= cols_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= s_axis_tuser;
      cur_q  <= s_axis_tdata;
      addr_q <= rd_addr;
    end
    if (state_q == S_CALC) begin
      x_q   <= x_d;
      sel_q <= sel_d;
      eor_q <= eor_d;
      eof_q <= eof_d;
    end
    if (out_load) begin
      out_data_q <= prod[RECIP_SHIFT +: SAMPLE_W];
      out_eor_q  <= eor_q;
      out_eof_q  <= eof_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_eor_q;
  assign m_axis_tuser  = out_eof_q;

  `CBS_ASSERT(a_col_in_row, ({1'b0, col_count_q} < eff_w), "column count beyond row width")
  `CBS_ASSERT(a_row_in_frame, ({1'b0, row_count_q} < eff_h), "row count beyond frame height")
  `CBS_ASSERT(a_pend_bound, ({1'b0, pending_q} <= w_plus1), "pending count beyond width + 1")
  `CBS_ASSERT_IMP(a_load_after_div, m_axis_tvalid && !$past(m_axis_tvalid),
                  $past(state_q) == S_DIV && $past(emit_q), "result loaded outside divide step")

endmodule
